### design/task_event_flag_unit_defines.svh
// ----------------------------------------------------------------------------
// task_event_flag_unit_defines.svh
// Assertion helpers shared by the event flag unit sources.
// ----------------------------------------------------------------------------
`ifndef TASK_EVENT_FLAG_UNIT_DEFINES_SVH
`define TASK_EVENT_FLAG_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TEFU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TEFU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tefu_pkg.sv
// ----------------------------------------------------------------------------
// tefu_pkg
// Types, sizes and codes shared by the task event flag unit.
// ----------------------------------------------------------------------------
package tefu_pkg;

  // Table geometry
  localparam int NUM_TASKS = 8;
  localparam int FLAG_BITS = 32;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Command codes
  localparam logic [2:0] CMD_WAIT    = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT = 3'd4;

  // Status codes
  localparam logic [2:0] ST_SUCCESS  = 3'd0;
  localparam logic [2:0] ST_NOT_MET  = 3'd1;
  localparam logic [2:0] ST_WAITING  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_NOT_WAIT = 3'd5;

  // Command item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  task_req;
    logic [31:0] flags;
    logic        wait_all;
    logic        may_block;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] flags_out;
    logic        woke;
    logic [2:0]  woke_task;
  } out_item_t;

  // One task table entry
  typedef struct packed {
    logic [FLAG_BITS-1:0] cur;
    logic [FLAG_BITS-1:0] want;
    logic                 mode;
    logic                 waiting;
  } entry_t;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [TASK_W-1:0] idx;
    entry_t            entry;
  } tbl_wr_t;

endpackage

### design/tefu_table.sv
// ----------------------------------------------------------------------------
// tefu_table
// Per-task flag table in flip-flops: one combinational read, one write port.
// ----------------------------------------------------------------------------
module tefu_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tefu_pkg::TASK_W-1:0] rd_idx,
  output tefu_pkg::entry_t          rd_entry,
  input  tefu_pkg::tbl_wr_t         wr
);

  localparam int DEPTH = 1 << tefu_pkg::TASK_W;

  tefu_pkg::entry_t tbl_r [DEPTH];

  // Read port
  assign rd_entry = tbl_r[rd_idx];

  // Write port; reset empties every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (wr.en) begin
      tbl_r[wr.idx] <= wr.entry;
    end
  end

endmodule

### design/tefu_exec.sv
// ----------------------------------------------------------------------------
// tefu_exec
// Command decode and flag arithmetic for one item: builds the result and the
// updated table entry from the registered command and the entry read.
// ----------------------------------------------------------------------------
module tefu_exec (
  input  tefu_pkg::in_item_t  item,
  input  tefu_pkg::entry_t    entry,
  output tefu_pkg::out_item_t result,
  output tefu_pkg::tbl_wr_t   wr
);

  logic [tefu_pkg::FLAG_BITS-1:0] mask;
  logic [tefu_pkg::FLAG_BITS-1:0] set_word;
  logic                           task_ok;
  logic                           mask_zero;
  logic [tefu_pkg::FLAG_BITS-1:0] snap;

  // Any/all wait condition
  function automatic logic cond_holds(input logic [tefu_pkg::FLAG_BITS-1:0] cur,
                                      input logic [tefu_pkg::FLAG_BITS-1:0] want,
                                      input logic                           all);
    logic [tefu_pkg::FLAG_BITS-1:0] hit;
    hit = cur & want;
    if (all) begin
      return hit == want;
    end
    return hit != '0;
  endfunction

  assign mask      = tefu_pkg::FLAG_BITS'(item.flags);
  assign mask_zero = (mask == '0);
  assign task_ok   = 32'(item.task_req) < 32'(tefu_pkg::NUM_TASKS);
  assign set_word  = entry.cur | mask;

  // Per-command update
  always_comb begin
    result           = '0;
    result.status    = tefu_pkg::ST_INVALID;
    wr.en            = 1'b0;
    wr.idx           = tefu_pkg::TASK_W'(item.task_req);
    wr.entry         = entry;
    snap             = '0;

    if (task_ok) begin
      unique case (item.cmd)
        tefu_pkg::CMD_WAIT: begin
          if (!mask_zero) begin
            wr.en         = 1'b1;
            wr.entry.want = mask;
            wr.entry.mode = item.wait_all;
            snap          = entry.cur;
            if (cond_holds(entry.cur, mask, item.wait_all)) begin
              wr.entry.cur     = entry.cur & ~mask;
              wr.entry.want    = '0;
              wr.entry.mode    = 1'b0;
              wr.entry.waiting = 1'b0;
              result.status    = tefu_pkg::ST_SUCCESS;
            end else if (!item.may_block) begin
              wr.entry.waiting = 1'b0;
              result.status    = tefu_pkg::ST_NOT_MET;
            end else begin
              wr.entry.waiting = 1'b1;
              result.status    = tefu_pkg::ST_WAITING;
            end
          end
        end
        tefu_pkg::CMD_SET: begin
          if (!mask_zero) begin
            wr.en         = 1'b1;
            snap          = set_word;
            wr.entry.cur  = set_word;
            result.status = tefu_pkg::ST_SUCCESS;
            // release a waiter whose condition now holds
            if (entry.waiting && cond_holds(set_word, entry.want, entry.mode)) begin
              wr.entry.cur     = set_word & ~entry.want;
              wr.entry.want    = '0;
              wr.entry.mode    = 1'b0;
              wr.entry.waiting = 1'b0;
              result.woke      = 1'b1;
              result.woke_task = item.task_req;
            end
          end
        end
        tefu_pkg::CMD_CLEAR: begin
          if (!mask_zero) begin
            wr.en         = 1'b1;
            snap          = entry.cur;
            wr.entry.cur  = entry.cur & ~mask;
            result.status = tefu_pkg::ST_SUCCESS;
          end
        end
        tefu_pkg::CMD_QUERY: begin
          snap          = entry.cur;
          result.status = tefu_pkg::ST_SUCCESS;
        end
        tefu_pkg::CMD_TIMEOUT: begin
          snap = entry.cur;
          if (entry.waiting) begin
            wr.en            = 1'b1;
            wr.entry.want    = '0;
            wr.entry.mode    = 1'b0;
            wr.entry.waiting = 1'b0;
            result.status    = tefu_pkg::ST_TIMEOUT;
          end else begin
            result.status    = tefu_pkg::ST_NOT_WAIT;
          end
        end
        default: begin
          // unknown command: stays invalid
        end
      endcase
    end

    result.flags_out = 32'(snap);
  end

endmodule

### design/task_event_flag_unit.sv
// ----------------------------------------------------------------------------
// task_event_flag_unit
// Per-task event flags with any/all waits. A command is registered on
// transfer, executed against the task table while it sits in the command
// register, and its result is held in an output register until transferred.
// One command per cycle is sustained while the result side accepts, set by
// the single read-modify-write of the flag table between the command and
// result registers. Back-pressure on the result side stalls the command
// register, which still frees up once the waiting result is transferred.
// ----------------------------------------------------------------------------
`include "task_event_flag_unit_defines.svh"

module task_event_flag_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tefu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tefu_pkg::out_item_t out_data
);

  tefu_pkg::in_item_t  cmd_r;
  logic                cmd_valid_r;
  logic                cmd_valid_nxt;
  tefu_pkg::out_item_t res_r;
  logic                res_valid_r;
  logic                res_valid_nxt;

  tefu_pkg::entry_t    rd_entry;
  tefu_pkg::out_item_t exec_res;
  tefu_pkg::tbl_wr_t   exec_wr;
  tefu_pkg::tbl_wr_t   tbl_wr;

  logic                in_xfer;
  logic                advance;

  // Handshake
  assign advance   = cmd_valid_r && (!res_valid_r || out_ready);
  assign in_ready  = !cmd_valid_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (in_xfer) begin
      cmd_valid_nxt = 1'b1;
    end else if (advance) begin
      cmd_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (out_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_data;
    end
    if (advance) begin
      res_r <= exec_res;
    end
  end

  // Table update only when the command moves to the result register
  always_comb begin
    tbl_wr    = exec_wr;
    tbl_wr.en = exec_wr.en && advance;
  end

  tefu_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (tefu_pkg::TASK_W'(cmd_r.task_req)),
    .rd_entry (rd_entry),
    .wr       (tbl_wr)
  );

  tefu_exec u_exec (
    .item   (cmd_r),
    .entry  (rd_entry),
    .result (exec_res),
    .wr     (exec_wr)
  );

  // Checks
  `TEFU_ASSERT_IMP(a_ready_when_free, clk, rst_n, !res_valid_r, in_ready,
                   "command stage blocked with result register free")
  `TEFU_ASSERT_NXT(a_advance_fills, clk, rst_n, advance, res_valid_r,
                   "advanced command produced no result")
  `TEFU_ASSERT_IMP(a_invalid_clean, clk, rst_n,
                   res_valid_r && (res_r.status == tefu_pkg::ST_INVALID),
                   (res_r.flags_out == '0) && !res_r.woke && (res_r.woke_task == '0),
                   "invalid result carries data")
  `TEFU_ASSERT_IMP(a_woke_success, clk, rst_n, res_valid_r && res_r.woke,
                   res_r.status == tefu_pkg::ST_SUCCESS, "wake reported without success")

endmodule

### tb/sv/task_event_flag_unit_test.sv
// ----------------------------------------------------------------------------
// task_event_flag_unit_test
// Self-checking bench for the event flag unit. A queue of commands (directed
// corner cases, then random traffic biased toward waits that later sets can
// release) feeds a valid/ready driver. Every command transfer runs through a
// local model of the task table, and each result transfer is checked field by
// field against the oldest predicted result. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module task_event_flag_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 900;
  localparam int CALM_TAIL   = 100;  // no idling once this few commands remain
  localparam int LONG_HOLD   = 80;   // receiver hold-off, in cycles
  localparam int HOLD_AFTER  = 300;  // command transfers before the hold-off
  localparam int DRAIN_WAIT  = 10;   // cycles after the last result

  typedef struct {
    tefu_pkg::in_item_t item;
    bit                 drain_first;  // hold off until every result has come back
  } cmd_slot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tefu_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tefu_pkg::out_item_t out_data;

  cmd_slot_t           pending_cmds[$];
  tefu_pkg::out_item_t expected_results[$];
  bit                  in_taken = 1'b0;
  bit                  failed = 1'b0;
  int                  cmd_xfers = 0;
  int                  send_gap = 0;
  int                  recv_gap = 0;
  int                  hold_left = 0;
  bit                  hold_done = 1'b0;

  // Local copy of the task table
  logic [tefu_pkg::FLAG_BITS-1:0] cur_word  [tefu_pkg::NUM_TASKS];
  logic [tefu_pkg::FLAG_BITS-1:0] want_word [tefu_pkg::NUM_TASKS];
  logic                           mode_all  [tefu_pkg::NUM_TASKS];
  logic                           waiting   [tefu_pkg::NUM_TASKS];

  task_event_flag_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic cond_met(logic [tefu_pkg::FLAG_BITS-1:0] word,
                                    logic [tefu_pkg::FLAG_BITS-1:0] want,
                                    logic need_all);
    return need_all ? ((word & want) == want) : ((word & want) != '0);
  endfunction

  // Wanted bits leave the word, the wait request is dropped
  function automatic void release_task(int t);
    cur_word[t]  = cur_word[t] & ~want_word[t];
    want_word[t] = '0;
    mode_all[t]  = 1'b0;
    waiting[t]   = 1'b0;
  endfunction

  // Runs one command against the table and returns its result
  function automatic tefu_pkg::out_item_t apply_flag_command(tefu_pkg::in_item_t c);
    tefu_pkg::out_item_t            r;
    logic [tefu_pkg::FLAG_BITS-1:0] mask;
    int                             t;
    r        = '0;
    r.status = tefu_pkg::ST_INVALID;
    mask     = c.flags[tefu_pkg::FLAG_BITS-1:0];
    t        = int'(c.task_req);
    if (t < tefu_pkg::NUM_TASKS) begin
      case (c.cmd)
        tefu_pkg::CMD_WAIT: if (mask != '0) begin
          want_word[t] = mask;
          mode_all[t]  = c.wait_all;
          r.flags_out  = 32'(cur_word[t]);
          if (cond_met(cur_word[t], mask, c.wait_all)) begin
            release_task(t);
            r.status = tefu_pkg::ST_SUCCESS;
          end else if (!c.may_block) begin
            waiting[t] = 1'b0;
            r.status   = tefu_pkg::ST_NOT_MET;
          end else begin
            waiting[t] = 1'b1;
            r.status   = tefu_pkg::ST_WAITING;
          end
        end
        tefu_pkg::CMD_SET: if (mask != '0) begin
          cur_word[t] = cur_word[t] | mask;
          r.flags_out = 32'(cur_word[t]);
          if (waiting[t] && cond_met(cur_word[t], want_word[t], mode_all[t])) begin
            release_task(t);
            r.woke      = 1'b1;
            r.woke_task = c.task_req;
          end
          r.status = tefu_pkg::ST_SUCCESS;
        end
        tefu_pkg::CMD_CLEAR: if (mask != '0) begin
          r.flags_out = 32'(cur_word[t]);
          cur_word[t] = cur_word[t] & ~mask;
          r.status    = tefu_pkg::ST_SUCCESS;
        end
        tefu_pkg::CMD_QUERY: begin
          r.flags_out = 32'(cur_word[t]);
          r.status    = tefu_pkg::ST_SUCCESS;
        end
        tefu_pkg::CMD_TIMEOUT: begin
          r.flags_out = 32'(cur_word[t]);
          if (waiting[t]) begin
            waiting[t]   = 1'b0;
            want_word[t] = '0;
            mode_all[t]  = 1'b0;
            r.status     = tefu_pkg::ST_TIMEOUT;
          end else begin
            r.status = tefu_pkg::ST_NOT_WAIT;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic add_cmd(logic [2:0] op, logic [2:0] idx, logic [31:0] mask,
                         logic need_all, logic blocking, bit drain = 1'b0);
    cmd_slot_t s;
    s.item.cmd       = op;
    s.item.task_req  = idx;
    s.item.flags     = mask;
    s.item.wait_all  = need_all;
    s.item.may_block = blocking;
    s.drain_first    = drain;
    pending_cmds.push_back(s);
  endtask

  // Mostly narrow masks so that sets can satisfy earlier waits
  function automatic logic [31:0] rand_mask();
    int pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0:       return '0;
      1:       return $urandom;
      2:       return '1;
      default: return 32'($urandom_range(1, 15))
                      << (($urandom_range(0, 3) == 0) ? $urandom_range(0, 28) : 0);
    endcase
  endfunction

  // Command and result transfers, prediction and checking
  always @(posedge clk) begin
    tefu_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_flag_command(in_data));
        in_taken = 1'b1;
        cmd_xfers++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_data);
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
            failed = 1'b1;
          end
          if (out_data.flags_out !== exp_r.flags_out) begin
            $error("flags_out: expected %h, got %h", exp_r.flags_out, out_data.flags_out);
            failed = 1'b1;
          end
          if (out_data.woke !== exp_r.woke) begin
            $error("woke: expected %0d, got %0d", exp_r.woke, out_data.woke);
            failed = 1'b1;
          end
          if (out_data.woke_task !== exp_r.woke_task) begin
            $error("woke_task: expected %0d, got %0d", exp_r.woke_task, out_data.woke_task);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Command driver
  always @(negedge clk) begin
    cmd_slot_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain_first && expected_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        in_data  <= nxt.item;
        in_valid <= 1'b1;
        if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 7);
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && cmd_xfers >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
        recv_gap = $urandom_range(1, 7);
    end
  end

  // Stimulus and end of run
  initial begin
    int         pick;
    logic [2:0] op;
    for (int t = 0; t < tefu_pkg::NUM_TASKS; t++) begin
      cur_word[t]  = '0;
      want_word[t] = '0;
      mode_all[t]  = 1'b0;
      waiting[t]   = 1'b0;
    end

    // Directed: empty table, zero masks, unknown commands
    add_cmd(tefu_pkg::CMD_QUERY,   3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_cmd(tefu_pkg::CMD_TIMEOUT, 3'd0, 32'h0000_0001, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd0, 32'h0,         1'b1, 1'b1);
    add_cmd(tefu_pkg::CMD_SET,     3'd1, 32'h0,         1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_CLEAR,   3'd2, 32'h0,         1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_TIMEOUT + 3'd1, 3'd3, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_cmd(tefu_pkg::CMD_TIMEOUT + 3'd2, 3'd5, 32'h0000_0001, 1'b0, 1'b1);
    add_cmd(tefu_pkg::CMD_TIMEOUT + 3'd3, 3'd7, 32'h8000_0000, 1'b1, 1'b0);
    // Immediate consume with all bits, not met, block and replace
    add_cmd(tefu_pkg::CMD_SET,     3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd7, 32'h8000_0001, 1'b1, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd3, 32'h0000_00F0, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd3, 32'h0000_0003, 1'b1, 1'b1);
    add_cmd(tefu_pkg::CMD_SET,     3'd3, 32'h0000_0001, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd3, 32'h0000_0100, 1'b0, 1'b1);
    add_cmd(tefu_pkg::CMD_SET,     3'd3, 32'h0000_0100, 1'b0, 1'b0);
    // Timeout of a waiting task
    add_cmd(tefu_pkg::CMD_WAIT,    3'd4, 32'hF000_0000, 1'b0, 1'b1);
    add_cmd(tefu_pkg::CMD_TIMEOUT, 3'd4, 32'h0,         1'b0, 1'b0);
    // Clear all, release on a full word, clear never releases
    add_cmd(tefu_pkg::CMD_SET,     3'd5, 32'hAAAA_AAAA, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_CLEAR,   3'd5, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_QUERY,   3'd5, 32'h0,         1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd6, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_cmd(tefu_pkg::CMD_SET,     3'd6, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_WAIT,    3'd2, 32'h0000_0001, 1'b0, 1'b1);
    add_cmd(tefu_pkg::CMD_CLEAR,   3'd2, 32'h0000_0001, 1'b0, 1'b0);
    add_cmd(tefu_pkg::CMD_TIMEOUT, 3'd2, 32'h0,         1'b0, 1'b0);

    // Random traffic; two commands wait for a fully drained pipeline
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 32)      op = tefu_pkg::CMD_WAIT;
      else if (pick < 62) op = tefu_pkg::CMD_SET;
      else if (pick < 74) op = tefu_pkg::CMD_CLEAR;
      else if (pick < 84) op = tefu_pkg::CMD_QUERY;
      else if (pick < 95) op = tefu_pkg::CMD_TIMEOUT;
      else                op = tefu_pkg::CMD_TIMEOUT + 3'($urandom_range(1, 3));
      add_cmd(op, 3'($urandom_range(0, tefu_pkg::NUM_TASKS - 1)), rand_mask(),
              1'($urandom), ($urandom_range(0, 9) < 7), (n == 100 || n == 600));
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Everything sent and every result back
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (failed || expected_results.size() != 0)
      $display("task_event_flag_unit test failed");
    else
      $display("task_event_flag_unit test passed");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("task_event_flag_unit test failed");
    $finish;
  end

endmodule
